// ===== design/spf_pkg.sv =====
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types, microcode table and constants of the stride prefetcher.
// ----------------------------------------------------------------------------
package spf_pkg;

  // fixed field widths
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned SHIFT_W    = 4;
  localparam int unsigned MISS_OFF_W = 12;

  // fixed miss offset list, in blocks
  localparam int unsigned NUM_MISS   = 9;
  localparam int unsigned MISS_IDX_W = 4;

  // reset value of the block size register
  localparam logic [SHIFT_W-1:0] BLOCK_SIZE_LOG2_RST = 4'd6;

  // microcode step addresses
  typedef logic [2:0] step_t;
  localparam step_t ST_IDLE   = 3'd0;
  localparam step_t ST_DISP   = 3'd1;
  localparam step_t ST_STRIDE = 3'd2;
  localparam step_t ST_MCHK   = 3'd3;
  localparam step_t ST_MISS   = 3'd4;

  // what a step sends to the output register
  typedef enum logic [1:0] {
    EMIT_NONE   = 2'd0,
    EMIT_STRIDE = 2'd1,
    EMIT_MISS   = 2'd2
  } emit_e;

  // datapath setup done by a step
  typedef enum logic [1:0] {
    DP_NOP         = 2'd0,
    DP_INIT_STRIDE = 2'd1,
    DP_INIT_MISS   = 2'd2
  } dp_e;

  // branch conditions
  typedef enum logic [2:0] {
    C_TRUE = 3'd0,
    C_SEEN = 3'd1,
    C_CONF = 3'd2,
    C_MISS = 3'd3,
    C_MORE = 3'd4
  } cond_e;

  // one control word
  typedef struct packed {
    logic  wait_in;
    emit_e emit;
    dp_e   dp;
    cond_e cond;
    step_t tgt_t;
    step_t tgt_f;
  } uword_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic seen;
    logic conf_nz;
    logic miss;
    logic more;
  } spf_stat_t;

  // control from the sequencer to the datapath
  typedef struct packed {
    uword_t w;
    logic   adv;
  } spf_ctl_t;

  // control store
  function automatic uword_t ucode(input step_t step);
    uword_t w;
    w = '{wait_in: 1'b1, emit: EMIT_NONE, dp: DP_NOP, cond: C_SEEN,
          tgt_t: ST_DISP, tgt_f: ST_IDLE};
    unique case (step)
      ST_IDLE:   w = '{wait_in: 1'b1, emit: EMIT_NONE, dp: DP_NOP, cond: C_SEEN,
                       tgt_t: ST_DISP, tgt_f: ST_IDLE};
      ST_DISP:   w = '{wait_in: 1'b0, emit: EMIT_NONE, dp: DP_INIT_STRIDE,
                       cond: C_CONF, tgt_t: ST_STRIDE, tgt_f: ST_MCHK};
      ST_STRIDE: w = '{wait_in: 1'b0, emit: EMIT_STRIDE, dp: DP_NOP, cond: C_MORE,
                       tgt_t: ST_STRIDE, tgt_f: ST_MCHK};
      ST_MCHK:   w = '{wait_in: 1'b0, emit: EMIT_NONE, dp: DP_INIT_MISS,
                       cond: C_MISS, tgt_t: ST_MISS, tgt_f: ST_IDLE};
      ST_MISS:   w = '{wait_in: 1'b0, emit: EMIT_MISS, dp: DP_NOP, cond: C_MORE,
                       tgt_t: ST_MISS, tgt_f: ST_IDLE};
      default:   w = '{wait_in: 1'b1, emit: EMIT_NONE, dp: DP_NOP, cond: C_TRUE,
                       tgt_t: ST_IDLE, tgt_f: ST_IDLE};
    endcase
    return w;
  endfunction

  // miss offsets in blocks
  function automatic logic signed [MISS_OFF_W-1:0] miss_off(
      input logic [MISS_IDX_W-1:0] idx);
    logic signed [MISS_OFF_W-1:0] o;
    o = '0;
    case (idx)
      4'd0:    o = 12'sd1;
      4'd1:    o = 12'sd2;
      4'd2:    o = 12'sd64;
      4'd3:    o = 12'sd128;
      4'd4:    o = -12'sd1088;
      4'd5:    o = -12'sd576;
      4'd6:    o = -12'sd64;
      4'd7:    o = 12'sd256;
      4'd8:    o = 12'sd512;
      default: o = '0;
    endcase
    return o;
  endfunction

endpackage

// ===== design/stride_prefetcher_core.sv =====
// ----------------------------------------------------------------------------
// stride_prefetcher_core
// Stride prefetcher with confidence, run by a small microcode sequencer.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------
//  in       | input     | in_valid_i/in_stall_o | addr_i, miss_i
//  out      | output    | out_valid_o/out_stall_i | prefetch_addr_o, last_o
//  cfg      | input     | cfg_we_i              | cfg_wdata_i (block_size_log2)
//
//  an access is taken in the idle step; the first one after reset returns to idle,
//  a later one runs dispatch, the stride loop if confidence is nonzero, the miss
//  check and the miss loop on a miss; one control step per cycle unless a step
//  waits on a handshake; one item leaves per cycle through the output register,
//  an out stall halts the emitting step; reset clears the step counter, history and confidence
// ----------------------------------------------------------------------------
module stride_prefetcher_core
  import spf_pkg::*;
#(
  parameter int unsigned SEQ_DEGREE   = 16,
  parameter int unsigned OTHER_DEGREE = 4,
  parameter int unsigned CONF_MAX     = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SHIFT_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ADDR_W-1:0]  addr_i,
  input  logic               miss_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ADDR_W-1:0]  prefetch_addr_o,
  output logic               last_o
);

  localparam int unsigned MAX_DEG = (SEQ_DEGREE > OTHER_DEGREE) ? SEQ_DEGREE : OTHER_DEGREE;
  localparam int unsigned MAX_CNT = (MAX_DEG > NUM_MISS) ? MAX_DEG : NUM_MISS;
  localparam int unsigned CNT_W   = $clog2(MAX_CNT);
  localparam int unsigned CONF_W  = $clog2(CONF_MAX + 1);

  spf_stat_t stat;
  spf_ctl_t  ctl;

  logic [SHIFT_W-1:0] sh_q;
  logic               seen_q, seen_d;
  logic [ADDR_W-1:0]  blk_q, blk_d;
  logic [ADDR_W-1:0]  stride_q, stride_d;
  logic [CONF_W-1:0]  conf_q, conf_d;
  logic               miss_q, miss_d;
  logic [ADDR_W-1:0]  acc_q, acc_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   lim_q, lim_d;
  logic               out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]  out_addr_q, out_addr_d;
  logic               out_last_q, out_last_d;

  logic               in_acc;
  logic               out_free;
  logic [ADDR_W-1:0]  bsize;
  logic [ADDR_W-1:0]  in_blk;
  logic [ADDR_W-1:0]  delta;
  logic               unit_stride;
  logic signed [MISS_OFF_W-1:0] miss_off_v;
  logic [ADDR_W-1:0]  miss_addr;
  logic               emit_go;

  spf_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  // handshake
  assign in_stall_o = !ctl.w.wait_in;
  assign in_acc     = ctl.w.wait_in && ctl.adv;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit_go    = ctl.adv && (ctl.w.emit != EMIT_NONE);

  assign stat = '{in_valid: in_valid_i, out_free: out_free, seen: seen_q,
                  conf_nz: (conf_q != '0), miss: miss_q, more: (cnt_q != lim_q)};

  // block alignment and delta
  assign bsize       = {{(ADDR_W-1){1'b0}}, 1'b1} << sh_q;
  assign in_blk      = addr_i & ({ADDR_W{1'b1}} << sh_q);
  assign delta       = in_blk - blk_q;
  assign unit_stride = (stride_q == bsize) || (stride_q == (~bsize + 1'b1));

  // fixed miss target for the current index
  assign miss_off_v = miss_off(cnt_q[MISS_IDX_W-1:0]);
  assign miss_addr  = blk_q + ({{(ADDR_W-MISS_OFF_W){miss_off_v[MISS_OFF_W-1]}},
                                miss_off_v} << sh_q);

  // history and confidence update on access
  always_comb begin
    seen_d   = seen_q;
    blk_d    = blk_q;
    stride_d = stride_q;
    conf_d   = conf_q;
    miss_d   = miss_q;
    if (in_acc) begin
      seen_d = 1'b1;
      blk_d  = in_blk;
      miss_d = miss_i;
      if (seen_q && (delta != '0)) begin
        if (delta == stride_q) begin
          if (conf_q < CONF_W'(CONF_MAX)) begin
            conf_d = conf_q + 1'b1;
          end
        end else begin
          conf_d   = '0;
          stride_d = delta;
        end
      end
    end
  end

  // accumulator and loop counter
  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    lim_d = lim_q;
    if (ctl.adv) begin
      case (ctl.w.dp)
        DP_INIT_STRIDE: begin
          acc_d = blk_q + stride_q;
          cnt_d = '0;
          lim_d = unit_stride ? CNT_W'(SEQ_DEGREE - 1) : CNT_W'(OTHER_DEGREE - 1);
        end
        DP_INIT_MISS: begin
          cnt_d = '0;
          lim_d = CNT_W'(NUM_MISS - 1);
        end
        default: ;
      endcase
      case (ctl.w.emit)
        EMIT_STRIDE: begin
          acc_d = acc_q + stride_q;
          cnt_d = cnt_q + 1'b1;
        end
        EMIT_MISS: cnt_d = cnt_q + 1'b1;
        default: ;
      endcase
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_addr_d  = out_addr_q;
    out_last_d  = out_last_q;
    if (emit_go) begin
      out_valid_d = 1'b1;
      if (ctl.w.emit == EMIT_STRIDE) begin
        out_addr_d = acc_q;
        out_last_d = (cnt_q == lim_q) && !miss_q;
      end else begin
        out_addr_d = miss_addr;
        out_last_d = (cnt_q == lim_q);
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_q        <= BLOCK_SIZE_LOG2_RST;
      seen_q      <= 1'b0;
      blk_q       <= '0;
      stride_q    <= '0;
      conf_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sh_q <= cfg_wdata_i;
      end
      seen_q      <= seen_d;
      blk_q       <= blk_d;
      stride_q    <= stride_d;
      conf_q      <= conf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and loop registers
  always_ff @(posedge clk_i) begin
    miss_q     <= miss_d;
    acc_q      <= acc_d;
    cnt_q      <= cnt_d;
    lim_q      <= lim_d;
    out_addr_q <= out_addr_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign prefetch_addr_o = out_addr_q;
  assign last_o          = out_last_q;

  // checks
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |-> (!out_valid_q || !out_stall_i))
    else $error("pending output item overwritten");

  a_conf_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conf_q <= CONF_W'(CONF_MAX))
    else $error("confidence above its limit");

  a_first_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !seen_q) |=> (ctl.w.wait_in && !(out_valid_o && !$past(out_valid_o))))
    else $error("first access did not return to idle silently");

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.w.emit != EMIT_NONE) |-> !in_acc)
    else $error("access taken during emission");

endmodule

// ===== design/spf_seq.sv =====
// ----------------------------------------------------------------------------
// spf_seq
// Microcode sequencer: step counter, control store fetch and branching.
// ----------------------------------------------------------------------------
module spf_seq
  import spf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  spf_stat_t stat_i,
  output spf_ctl_t  ctl_o
);

  step_t  step_q, step_d;
  uword_t w;
  logic   adv;
  logic   cond_ok;

  // fetch current control word
  assign w = ucode(step_q);

  // a waiting step finishes when its input or output side is ready, any other step always finishes
  always_comb begin
    if (w.wait_in) begin
      adv = stat_i.in_valid;
    end else if (w.emit != EMIT_NONE) begin
      adv = stat_i.out_free;
    end else begin
      adv = 1'b1;
    end
  end

  // branch condition
  always_comb begin
    unique case (w.cond)
      C_TRUE:  cond_ok = 1'b1;
      C_SEEN:  cond_ok = stat_i.seen;
      C_CONF:  cond_ok = stat_i.conf_nz;
      C_MISS:  cond_ok = stat_i.miss;
      C_MORE:  cond_ok = stat_i.more;
      default: cond_ok = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    step_d = step_q;
    if (adv) begin
      step_d = cond_ok ? w.tgt_t : w.tgt_f;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctl_o = '{w: w, adv: adv};

endmodule

// ===== verif/stride_prefetcher_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stride_prefetcher_core_tb
// Self-checking bench for the stride prefetcher. Accesses go in through the
// valid/stall channel with random gaps. A local model of the stride,
// confidence and miss logic predicts every prefetch item, and each item that
// leaves the block is compared with the oldest prediction. Directed cases come
// first. Random stride streams and noise then run under several block sizes.
// ----------------------------------------------------------------------------
module stride_prefetcher_core_tb;
  import spf_pkg::*;

  localparam int unsigned SEQ_DEG   = 16;
  localparam int unsigned OTHER_DEG = 4;
  localparam int unsigned CONF_TOP  = 3;
  localparam int          IDLE_WAIT = 40;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              last;
  } prefetch_t;

  // fixed miss offsets, in blocks
  localparam longint MISS_OFFS [NUM_MISS] = '{1, 2, 64, 128, -1088, -576, -64, 256, 512};

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [SHIFT_W-1:0] cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [ADDR_W-1:0]  addr_i;
  logic               miss_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [ADDR_W-1:0]  prefetch_addr_o;
  logic               last_o;

  // expected prefetch items, oldest first
  prefetch_t pending_pf[$];
  int        err_cnt = 0;

  // history of the local model
  logic               pf_seen;
  logic [ADDR_W-1:0]  pf_prev_blk;
  logic [ADDR_W-1:0]  pf_stride;
  logic [1:0]         pf_conf;
  logic [SHIFT_W-1:0] pf_shift;

  // idling controls
  bit in_gap_on  = 1'b1;
  bit out_gap_on = 1'b1;
  int in_gap     = 0;
  bit in_hold    = 1'b0;
  int stall_left = 0;

  stride_prefetcher_core #(
    .SEQ_DEGREE  (SEQ_DEG),
    .OTHER_DEGREE(OTHER_DEG),
    .CONF_MAX    (CONF_TOP)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .addr_i         (addr_i),
    .miss_i         (miss_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .prefetch_addr_o(prefetch_addr_o),
    .last_o         (last_o)
  );

  // clock, 10 ns period
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // predict the prefetch items of one accepted access
  task automatic predict_access(input logic [ADDR_W-1:0] a, input logic m);
    logic [ADDR_W-1:0] bsz;
    logic [ADDR_W-1:0] blk;
    logic [ADDR_W-1:0] delta;
    int                deg;
    int                total;
    int                k;
    prefetch_t         e;
    bsz = 64'd1 << pf_shift;
    blk = a & ~(bsz - 64'd1);
    if (!pf_seen) begin
      pf_seen     = 1'b1;
      pf_prev_blk = blk;
      return;
    end
    delta = blk - pf_prev_blk;
    if (delta != '0) begin
      if (delta == pf_stride) begin
        if (pf_conf < CONF_TOP) pf_conf = pf_conf + 2'd1;
      end else begin
        pf_conf   = '0;
        pf_stride = delta;
      end
    end
    // unit stride either way gets the long run
    deg   = (pf_stride == bsz || pf_stride == -bsz) ? SEQ_DEG : OTHER_DEG;
    total = ((pf_conf >= 2'd1) ? deg : 0) + (m ? NUM_MISS : 0);
    k     = 0;
    if (pf_conf >= 2'd1) begin
      for (int d = 1; d <= deg; d++) begin
        k          = k + 1;
        e.addr     = blk + 64'(d) * pf_stride;
        e.last     = (k == total);
        pending_pf = {pending_pf, e};
      end
    end
    if (m) begin
      for (int i = 0; i < NUM_MISS; i++) begin
        k          = k + 1;
        e.addr     = blk + 64'(MISS_OFFS[i]) * bsz;
        e.last     = (k == total);
        pending_pf = {pending_pf, e};
      end
    end
    pf_prev_blk = blk;
  endtask

  // send one access item and predict it once it is taken
  task automatic send_access(input logic [ADDR_W-1:0] a, input logic m);
    repeat (in_gap) @(posedge clk_i);
    in_valid_i <= 1'b1;
    addr_i     <= a;
    miss_i     <= m;
    do @(posedge clk_i); while (in_stall_o);
    predict_access(a, m);
    in_gap = in_gap_on ? $urandom_range(0, 11) : 0;
    if (in_gap > 0) in_valid_i <= 1'b0;
    in_hold = (in_gap == 0);
  endtask

  // let every pending prefetch come out, then let the block settle
  task automatic wait_idle();
    if (in_hold) begin
      in_valid_i <= 1'b0;
      in_hold = 1'b0;
    end
    while (pending_pf.size() != 0) @(posedge clk_i);
    repeat (IDLE_WAIT) @(posedge clk_i);
  endtask

  // block size register write, only while idle
  task automatic write_block_size(input logic [SHIFT_W-1:0] v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pf_shift = v;
  endtask

  // output side: random stall per item, compare each item with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pf.size() == 0) begin
        $display("%0t: unexpected prefetch item, expected none, got addr %h last %b",
                 $time, prefetch_addr_o, last_o);
        err_cnt++;
      end else begin
        if (prefetch_addr_o !== pending_pf[0].addr) begin
          $display("%0t: prefetch_addr expected %h, got %h",
                   $time, pending_pf[0].addr, prefetch_addr_o);
          err_cnt++;
        end
        if (last_o !== pending_pf[0].last) begin
          $display("%0t: last expected %b, got %b", $time, pending_pf[0].last, last_o);
          err_cnt++;
        end
        void'(pending_pf.pop_front());
      end
      stall_left = out_gap_on ? $urandom_range(0, 11) : 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left > 0);
  end

  // first access after reset, then unit stride up to saturation with a zero delta
  task automatic test_unit_stride();
    send_access(64'h1000, 1'b1);
    send_access(64'h1044, 1'b0);
    send_access(64'h1080, 1'b0);
    send_access(64'h10bf, 1'b1);
    send_access(64'h10c0, 1'b0);
    send_access(64'h1100, 1'b0);
    send_access(64'h1140, 1'b1);
  endtask

  // stride of minus one block
  task automatic test_backward_stride();
    send_access(64'h9000, 1'b0);
    send_access(64'h8fc0, 1'b0);
    send_access(64'h8f80, 1'b1);
  endtask

  // non-unit stride, then a broken stream with a miss
  task automatic test_other_stride();
    send_access(64'h20000, 1'b0);
    send_access(64'h200c0, 1'b0);
    send_access(64'h20180, 1'b0);
    send_access(64'h30000, 1'b1);
  endtask

  // top and bottom of the address range, with wraparound
  task automatic test_address_extremes();
    send_access(64'hffff_ffff_ffff_ff80, 1'b0);
    send_access(64'hffff_ffff_ffff_ffc0, 1'b0);
    send_access(64'h0, 1'b0);
    send_access(64'hffff_ffff_ffff_ffff, 1'b1);
    send_access(64'h0, 1'b1);
  endtask

  // random stride streams mixed with noise
  task automatic run_streams(input int n_items);
    int                sent;
    int                len;
    int                kind;
    int                k;
    logic [ADDR_W-1:0] bsz;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] step;
    logic [ADDR_W-1:0] a;
    sent = 0;
    bsz  = 64'd1 << pf_shift;
    while (sent < n_items) begin
      in_gap_on  = ($urandom_range(0, 3) != 0);
      out_gap_on = ($urandom_range(0, 3) != 0);
      kind       = $urandom_range(0, 9);
      if (kind < 7) begin
        len  = $urandom_range(3, 10);
        base = {$urandom, $urandom};
        case ($urandom_range(0, 3))
          0: step = bsz;
          1: step = -bsz;
          2: begin
            k    = $urandom_range(0, 16) - 8;
            step = 64'(longint'(k)) * bsz;
          end
          default: step = {$urandom, $urandom};
        endcase
        for (int j = 0; j < len; j++) begin
          // an access now and then stays in the same block
          if ($urandom_range(0, 7) != 0) base = base + step;
          a = (base & ~(bsz - 64'd1)) | ({$urandom, $urandom} & (bsz - 64'd1));
          send_access(a, $urandom_range(0, 3) == 0);
          sent++;
        end
      end else begin
        len = $urandom_range(1, 4);
        for (int j = 0; j < len; j++) begin
          send_access({$urandom, $urandom}, 1'($urandom_range(0, 1)));
          sent++;
        end
      end
    end
  endtask

  // smallest, largest and other large block sizes
  task automatic test_block_sizes();
    write_block_size(4'd0);
    run_streams(20);
    write_block_size(4'd12);
    run_streams(20);
    write_block_size(4'd15);
    run_streams(20);
    write_block_size(4'd13);
    run_streams(20);
  endtask

  // random block sizes, ending back at the reset size
  task automatic test_random_streams();
    for (int p = 0; p < 6; p++) begin
      write_block_size(SHIFT_W'($urandom_range(0, 15)));
      run_streams(20);
    end
    write_block_size(BLOCK_SIZE_LOG2_RST);
    run_streams(20);
  endtask

  // main sequence
  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    addr_i      = '0;
    miss_i      = 1'b0;
    out_stall_i = 1'b0;
    pf_seen     = 1'b0;
    pf_prev_blk = '0;
    pf_stride   = '0;
    pf_conf     = '0;
    pf_shift    = BLOCK_SIZE_LOG2_RST;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unit_stride();
    test_backward_stride();
    test_other_stride();
    test_address_extremes();
    test_block_sizes();
    test_random_streams();

    wait_idle();
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit
  initial begin
    #(64'd5_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
